FILE: hw/rtl/pib_pkg.sv
// Package for project_into_bounds: types, constants and saturating helpers.
package pib_pkg;

  localparam int unsigned QW  = 32;   // Q16.16 word width
  localparam int unsigned KW  = 17;   // configuration register width
  localparam int unsigned PW  = 31;   // saturated non-negative product width
  localparam int unsigned FRAC = 16;

  localparam logic [QW-1:0] Q_ONE    = 32'h0001_0000;
  localparam logic [QW-1:0] Q_MARGIN = 32'h0000_0001;
  localparam logic [KW-1:0] PUSH_FACTOR_RESET  = 17'd655;
  localparam logic [KW-1:0] GAP_FRACTION_RESET = 17'd655;

  typedef enum logic [1:0] {
    REG_PUSH_FACTOR  = 2'd0,
    REG_GAP_FRACTION = 2'd1
  } cfg_reg_t;

  // One element as captured from the input stream.
  typedef struct packed {
    logic signed [QW-1:0] value;
    logic signed [QW-1:0] lower;
    logic signed [QW-1:0] upper;
    logic                 has_lower;
    logic                 has_upper;
    logic                 last;
  } in_item_t;

  // Element plus the scaled pushes and the gap cap.
  typedef struct packed {
    in_item_t        item;
    logic            inverted;
    logic [PW-1:0]   push_lo;
    logic [PW-1:0]   push_up;
    logic [PW-1:0]   cap_raw;
  } mid_item_t;

  // Finished result.
  typedef struct packed {
    logic signed [QW-1:0] value;
    logic                 bounds_inverted;
    logic                 vector_ok;
    logic                 last;
  } out_item_t;

  function automatic logic signed [QW-1:0] add_sat(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end
    return s[QW-1:0];
  endfunction

  function automatic logic signed [QW-1:0] sub_sat(input logic signed [QW-1:0] a,
                                                   input logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      return s[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end
    return s[QW-1:0];
  endfunction

  // (k * m) >> 16, saturated to the non-negative 31-bit range.
  function automatic logic [PW-1:0] qmul_sat(input logic [KW-1:0] k,
                                             input logic [QW-1:0] m);
    logic [KW+QW-1:0] p;
    logic [KW+QW-FRAC-1:0] sh;
    p  = (KW+QW)'(k) * (KW+QW)'(m);
    sh = p[KW+QW-1:FRAC];
    if (|sh[KW+QW-FRAC-1:PW]) begin
      return {PW{1'b1}};
    end
    return sh[PW-1:0];
  endfunction

endpackage

FILE: hw/rtl/pib_push_calc.sv
// Scaled bound pushes, gap cap and inverted-bounds test for one element.
module pib_push_calc (
  input  pib_pkg::in_item_t          item,
  input  logic [pib_pkg::KW-1:0]     push_factor,
  input  logic [pib_pkg::KW-1:0]     gap_fraction,
  output pib_pkg::mid_item_t         mid
);
  import pib_pkg::*;

  logic [QW-1:0] lo_abs;
  logic [QW-1:0] up_abs;
  logic [QW-1:0] lo_mag;
  logic [QW-1:0] up_mag;
  logic [QW:0]   gap;

  always_comb begin
    lo_abs = item.lower[QW-1] ? (~item.lower + 1'b1) : item.lower;
    up_abs = item.upper[QW-1] ? (~item.upper + 1'b1) : item.upper;
    // The magnitude behind each push never shrinks below one unit of the bound scale.
    lo_mag = (lo_abs < Q_ONE) ? Q_ONE : lo_abs;
    up_mag = (up_abs < Q_ONE) ? Q_ONE : up_abs;
    gap    = {item.upper[QW-1], item.upper} - {item.lower[QW-1], item.lower};

    mid.item     = item;
    mid.inverted = gap[QW];
    mid.push_lo  = qmul_sat(push_factor, lo_mag);
    mid.push_up  = qmul_sat(push_factor, up_mag);
    mid.cap_raw  = qmul_sat(gap_fraction, gap[QW-1:0]);
  end

endmodule

FILE: hw/rtl/pib_select.sv
// Target selection, clamping and vector failure bookkeeping for one element.
module pib_select (
  input  pib_pkg::mid_item_t  mid,
  input  logic                failed,
  output pib_pkg::out_item_t  res,
  output logic                failed_next
);
  import pib_pkg::*;

  logic signed [QW-1:0] cap;
  logic signed [QW-1:0] pl;
  logic signed [QW-1:0] pu;
  logic signed [QW-1:0] plc;
  logic signed [QW-1:0] puc;
  logic signed [QW-1:0] t_lo;
  logic signed [QW-1:0] t_up;
  logic signed [QW-1:0] t_lo1;
  logic signed [QW-1:0] t_up1;
  logic signed [QW-1:0] x;
  logic                 both;
  logic                 fail_now;

  always_comb begin
    pl    = {1'b0, mid.push_lo};
    pu    = {1'b0, mid.push_up};
    cap   = $signed({1'b0, mid.cap_raw}) - $signed(Q_MARGIN);
    plc   = (pl > cap) ? cap : pl;
    puc   = (pu > cap) ? cap : pu;
    t_lo  = add_sat(mid.item.lower, plc);
    t_up  = sub_sat(mid.item.upper, puc);
    t_lo1 = sub_sat(add_sat(mid.item.lower, pl), Q_MARGIN);
    t_up1 = sub_sat(sub_sat(mid.item.upper, pu), Q_MARGIN);
    both  = mid.item.has_lower & mid.item.has_upper;
    fail_now = failed | (both & mid.inverted);

    x = mid.item.value;
    if (!fail_now) begin
      priority if (both) begin
        if (x < t_lo) begin
          x = t_lo;
        end else if (x > t_up) begin
          x = t_up;
        end
      end else if (mid.item.has_lower) begin
        if (x < t_lo1) x = t_lo1;
      end else if (mid.item.has_upper) begin
        if (x > t_up1) x = t_up1;
      end else begin
        // Free elements pass through unchanged.
        x = mid.item.value;
      end
    end

    res.value           = x;
    res.bounds_inverted = fail_now;
    res.vector_ok       = mid.item.last & ~fail_now;
    res.last            = mid.item.last;
    failed_next         = mid.item.last ? 1'b0 : fail_now;
  end

endmodule

FILE: hw/rtl/project_into_bounds.sv
// Top level of project_into_bounds: stream ports, pipeline registers, configuration.
//
//  channel   direction  accepted when          contents
//  s_*       in         s_tvalid & s_tready    element: value, bounds, flags, last
//  m_*       out        m_tvalid & m_tready    projected value, verdict flags, last
//  cfg_*     in         cfg_wr_en              push_factor (0), gap_fraction (1)
//
// Every element gives exactly one result, which passes through the input register,
// the product register behind the three multipliers and the result register, and
// one request can be taken in every cycle while the output side does not stall.
// Reset (rst, synchronous) empties the pipeline, clears the vector failure flag and
// loads both configuration registers with 655.
// A stall on the output side holds the result register and backs up through
// the pipeline; each stage still loads whenever the stage ahead frees up.
module project_into_bounds (
  input  logic                      clk,
  input  logic                      rst,
  // Input stream.
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [95:0]               s_tdata,   // value_in, lower_bound, upper_bound
  input  logic [1:0]                s_tuser,   // has_lower, has_upper
  input  logic                      s_tlast,   // last_in
  // Output stream.
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,   // value_out
  output logic [1:0]                m_tuser,   // bounds_inverted, vector_ok
  output logic                      m_tlast,   // last_out
  // Configuration writes.
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [pib_pkg::KW-1:0]    cfg_data
);
  import pib_pkg::*;

  logic [KW-1:0] push_factor;
  logic [KW-1:0] gap_fraction;
  logic          failed_flag;
  logic          failed_flag_next;

  in_item_t      in_reg;
  logic          in_valid;
  mid_item_t     mid_reg;
  mid_item_t     mid_next;
  logic          mid_valid;
  out_item_t     out_reg;
  out_item_t     out_next;
  logic          out_valid;

  logic          out_ready;
  logic          mid_ready;

  // A stage can load when it is empty or its contents move on this cycle.
  assign out_ready = ~out_valid | m_tready;
  assign mid_ready = ~mid_valid | out_ready;
  assign s_tready  = ~in_valid | mid_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      push_factor  <= PUSH_FACTOR_RESET;
      gap_fraction <= GAP_FRACTION_RESET;
    end else if (cfg_wr_en) begin
      // Indexes beyond the two registers are ignored.
      if (cfg_index == REG_PUSH_FACTOR)  push_factor  <= cfg_data;
      if (cfg_index == REG_GAP_FRACTION) gap_fraction <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_reg.value     <= s_tdata[31:0];
      in_reg.lower     <= s_tdata[63:32];
      in_reg.upper     <= s_tdata[95:64];
      in_reg.has_lower <= s_tuser[0];
      in_reg.has_upper <= s_tuser[1];
      in_reg.last      <= s_tlast;
    end
  end

  pib_push_calc u_calc (
    .item         (in_reg),
    .push_factor  (push_factor),
    .gap_fraction (gap_fraction),
    .mid          (mid_next)
  );

  // Product register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && in_valid) begin
      mid_reg <= mid_next;
    end
  end

  pib_select u_select (
    .mid         (mid_reg),
    .failed      (failed_flag),
    .res         (out_next),
    .failed_next (failed_flag_next)
  );

  // Result register; the failure flag moves in step with the results, so
  // every element sees the verdict of the ones ahead of it in the vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      failed_flag <= 1'b0;
    end else if (out_ready) begin
      out_valid <= mid_valid;
      if (mid_valid) failed_flag <= failed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mid_valid) begin
      out_reg <= out_next;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_reg.value;
  assign m_tuser[0] = out_reg.bounds_inverted;
  assign m_tuser[1] = out_reg.vector_ok;
  assign m_tlast    = out_reg.last;

  // A passing verdict only comes with the last element of a vector.
  a_ok_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
    else $error("vector_ok outside a clean last element");

  // A failure reported mid-vector must still be held for the later elements.
  a_fail_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] && !m_tlast) |-> failed_flag)
    else $error("failure flag lost before the end of the vector");

  // With the result register empty the whole pipeline can advance.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result register");

endmodule

FILE: sim/pib_checker.sv
// Checker for project_into_bounds: predicts every result and compares it with the output stream.
`timescale 1ns / 100ps

module pib_checker
  import pib_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [95:0]         s_tdata,   // value_in, lower_bound, upper_bound
  input  logic [1:0]          s_tuser,   // has_lower, has_upper
  input  logic                s_tlast,   // last_in
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [31:0]         m_tdata,   // value_out
  input  logic [1:0]          m_tuser,   // bounds_inverted, vector_ok
  input  logic                m_tlast,   // last_out
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [KW-1:0]       cfg_data,
  output int                  error_count,
  output int                  outstanding
);

  typedef logic signed [35:0] wide_t;

  localparam wide_t WORD_MAX = 36'sd2147483647;
  localparam wide_t WORD_MIN = -36'sd2147483648;
  localparam wide_t UNIT     = 36'sd65536;
  localparam wide_t STEP     = 36'sd1;
  localparam int    REPORT_LIMIT = 10;

  logic [KW-1:0] push_k;
  logic [KW-1:0] gap_k;
  logic          vector_failed;
  out_item_t     projected_q[$];
  in_item_t      elem;
  out_item_t     want;
  out_item_t     got;
  int            errs;

  function automatic wide_t clip_word(wide_t v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // (k * mag) >> 16 for a non-negative magnitude below 2^33, saturated.
  function automatic wide_t scale_by(logic [KW-1:0] k, wide_t mag);
    logic [49:0] prod;
    prod = 50'(k) * 50'(mag[32:0]);
    prod = prod >> 16;
    if (prod > 50'd2147483647) return WORD_MAX;
    return {5'd0, prod[30:0]};
  endfunction

  // Push away from bound b: k * max(1.0, |b|).
  function automatic wide_t bound_push(logic [KW-1:0] k, logic signed [31:0] b);
    wide_t mag;
    mag = b;
    if (mag < 0) mag = -mag;
    if (mag < UNIT) mag = UNIT;
    return scale_by(k, mag);
  endfunction

  function automatic out_item_t project_element(in_item_t e);
    wide_t     x;
    wide_t     lo;
    wide_t     up;
    wide_t     cap;
    wide_t     pl;
    wide_t     pu;
    wide_t     t;
    logic      fails;
    out_item_t r;
    x     = $signed(e.value);
    lo    = $signed(e.lower);
    up    = $signed(e.upper);
    fails = vector_failed;
    if (!fails) begin
      if (e.has_lower && e.has_upper) begin
        if (lo > up) begin
          fails = 1'b1;
        end else begin
          // The cap may come out negative on a zero gap and is used as it is.
          cap = scale_by(gap_k, up - lo) - STEP;
          pl  = bound_push(push_k, e.lower);
          pu  = bound_push(push_k, e.upper);
          if (pl > cap) pl = cap;
          if (pu > cap) pu = cap;
          t = clip_word(lo + pl);
          if (x < t) begin
            x = t;
          end else begin
            t = clip_word(up - pu);
            if (x > t) x = t;
          end
        end
      end else if (e.has_lower) begin
        t = clip_word(clip_word(lo + bound_push(push_k, e.lower)) - STEP);
        if (x < t) x = t;
      end else if (e.has_upper) begin
        t = clip_word(clip_word(up - bound_push(push_k, e.upper)) - STEP);
        if (x > t) x = t;
      end
    end
    r.value           = x[31:0];
    r.bounds_inverted = fails;
    r.vector_ok       = e.last && !fails;
    r.last            = e.last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      projected_q.delete();
      push_k        = PUSH_FACTOR_RESET;
      gap_k         = GAP_FRACTION_RESET;
      vector_failed = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PUSH_FACTOR:  push_k = cfg_data;
          REG_GAP_FRACTION: gap_k  = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        elem.value     = s_tdata[31:0];
        elem.lower     = s_tdata[63:32];
        elem.upper     = s_tdata[95:64];
        elem.has_lower = s_tuser[0];
        elem.has_upper = s_tuser[1];
        elem.last      = s_tlast;
        want           = project_element(elem);
        vector_failed  = elem.last ? 1'b0 : want.bounds_inverted;
        projected_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.value           = m_tdata;
        got.bounds_inverted = m_tuser[0];
        got.vector_ok       = m_tuser[1];
        got.last            = m_tlast;
        if (projected_q.size() == 0) begin
          if (errs < REPORT_LIMIT)
            $display("%0t: result with nothing pending: value %h inv %b ok %b last %b",
                     $realtime, got.value, got.bounds_inverted, got.vector_ok, got.last);
          errs++;
        end else begin
          want = projected_q.pop_front();
          if (got.value !== want.value || got.bounds_inverted !== want.bounds_inverted ||
              got.vector_ok !== want.vector_ok || got.last !== want.last) begin
            if (errs < REPORT_LIMIT)
              $display("%0t: mismatch: expected value %h inv %b ok %b last %b, got %h %b %b %b",
                       $realtime, want.value, want.bounds_inverted, want.vector_ok, want.last,
                       got.value, got.bounds_inverted, got.vector_ok, got.last);
            errs++;
          end
        end
      end
    end
    outstanding <= projected_q.size();
    error_count <= errs;
  end

  initial begin
    errs        = 0;
    error_count = 0;
    outstanding = 0;
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for project_into_bounds: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 100ps

module tb_top;
  import pib_pkg::*;

  // Word corners in Q16.16.
  localparam logic signed [31:0] WMIN = 32'sh8000_0000;
  localparam logic signed [31:0] WMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WONE = 32'sh0001_0000;

  // Register indexes that the block decodes to nothing.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 144;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  // Per-phase register settings (-1 draws a random value) and idling percentages.
  localparam int PHASE_PF[PHASES]    = '{0, 65536, 131071, 655, -1, 0, 65536, 6554};
  localparam int PHASE_GF[PHASES]    = '{0, 65536, 131071, 655, -1, 65536, 0, 32768};
  localparam int PHASE_SIDLE[PHASES] = '{0, 80, 0, 22, 0, 80, 0, 22};
  localparam int PHASE_RSTALL[PHASES] = '{0, 0, 80, 22, 0, 0, 80, 22};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [95:0]   s_tdata = '0;   // value_in, lower_bound, upper_bound
  logic [1:0]    s_tuser = '0;   // has_lower, has_upper
  logic          s_tlast = 1'b0; // last_in
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [31:0]   m_tdata;        // value_out
  logic [1:0]    m_tuser;        // bounds_inverted, vector_ok
  logic          m_tlast;        // last_out
  logic          cfg_wr_en = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic [KW-1:0] cfg_data = '0;

  int error_count;
  int outstanding;
  int send_idle   = 0;
  int recv_stall  = 0;
  int quiet_cycles = 0;

  project_into_bounds u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pib_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // The receiver drops ready at random, with the stall rate of the current phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // The watchdog ends the run when no request moves on either side for too long.
  // A lost or stuck result shows up here, since the drain at the end never completes.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > longint'(WMAX)) return WMAX;
    if (v < longint'(WMIN)) return WMIN;
    return v[31:0];
  endfunction

  function automatic in_item_t element(logic signed [31:0] value, logic signed [31:0] lower,
                                       logic signed [31:0] upper, logic hl, logic hu,
                                       logic last);
    in_item_t e;
    e.value     = value;
    e.lower     = lower;
    e.upper     = upper;
    e.has_lower = hl;
    e.has_upper = hu;
    e.last      = last;
    return e;
  endfunction

  // A word that leans toward the interesting spots: corners, the unit range and
  // magnitudes spread across every octave, plus plain full-range noise.
  function automatic logic signed [31:0] pick_word();
    logic signed [31:0] w;
    case ($urandom_range(4))
      0: w = $urandom;
      1: w = int'($urandom_range(2097152)) - 1048576;
      2: begin
        case ($urandom_range(5))
          0: w = WMIN;
          1: w = WMAX;
          2: w = 0;
          3: w = WONE;
          4: w = -WONE;
          default: w = 1;
        endcase
      end
      3: begin
        w = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) w = -w;
      end
      default: w = int'($urandom_range(131072)) - 65536;
    endcase
    return w;
  endfunction

  // One element of a well-formed vector: consistent bounds most of the time, an
  // inverted pair now and then, and a value near a bound, between them or anywhere.
  function automatic in_item_t random_element(logic last);
    in_item_t           e;
    longint             gap;
    logic signed [31:0] tmp;
    e.has_lower = ($urandom_range(3) != 0);
    e.has_upper = ($urandom_range(3) != 0);
    e.last      = last;
    e.lower     = pick_word();
    case ($urandom_range(3))
      0: gap = longint'($urandom);
      1: gap = longint'($urandom_range(262144));
      2: gap = 0;
      default: gap = longint'($urandom >> $urandom_range(31));
    endcase
    e.upper = clip32(longint'(e.lower) + gap);
    if ($urandom_range(99) < 6) begin
      tmp     = e.lower;
      e.lower = e.upper;
      e.upper = tmp;
    end
    case ($urandom_range(4))
      0: e.value = clip32(longint'(e.lower) + longint'($urandom_range(8192)) - 4096);
      1: e.value = clip32(longint'(e.upper) + longint'($urandom_range(8192)) - 4096);
      2: e.value = clip32(longint'(e.lower) + longint'($urandom_range(1048576)) - 524288);
      3: e.value = clip32(longint'(e.upper) + longint'($urandom_range(1048576)) - 524288);
      default: e.value = pick_word();
    endcase
    return e;
  endfunction

  // Offers one request and holds it until the block takes it. An idle gap lowers
  // valid first; otherwise valid stays high straight into the next request.
  task automatic send_one(in_item_t e);
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {e.upper, e.lower, e.value};
    s_tuser  <= {e.has_upper, e.has_lower};
    s_tlast  <= e.last;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops offering requests and waits until every predicted result has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Sends whole vectors of random length until at least n elements have gone out.
  // With pause set, the sender also stops halfway and lets the pipeline run dry.
  task automatic send_vectors(int n, bit pause);
    int sent;
    int len;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n) begin
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_one(random_element(i == len - 1));
        sent++;
      end
      if (pause && !paused && sent >= n / 2) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // Register writes go out on back-to-back cycles; the caller drops enable once at the end.
  task automatic write_reg(logic [1:0] index, logic [KW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  initial begin
    logic [KW-1:0] pf;
    logic [KW-1:0] gf;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed elements at the reset register values, with no idling.
    // Free elements pass through at the word corners.
    send_one(element(WMIN, 0, 0, 1'b0, 1'b0, 1'b0));
    send_one(element(WMAX, WMAX, WMIN, 1'b0, 1'b0, 1'b0));
    // Lower bound only: raised, saturated at the top, and the most negative bound.
    send_one(element(WMIN, 0, 0, 1'b1, 1'b0, 1'b0));
    send_one(element(0, WMAX, 0, 1'b1, 1'b0, 1'b0));
    send_one(element(WMIN, WMIN, 0, 1'b1, 1'b0, 1'b0));
    // Upper bound only: saturated at the bottom, and a value already inside.
    send_one(element(WMAX, 0, WMIN, 1'b0, 1'b1, 1'b0));
    send_one(element(WMAX, 0, WMAX, 1'b0, 1'b1, 1'b0));
    send_one(element(-WONE, 0, WONE, 1'b0, 1'b1, 1'b0));
    // Both bounds: raised, lowered and left alone.
    send_one(element(WMIN, -WONE, WONE, 1'b1, 1'b1, 1'b0));
    send_one(element(WMAX, -WONE, WONE, 1'b1, 1'b1, 1'b0));
    send_one(element(0, -WONE, WONE, 1'b1, 1'b1, 1'b0));
    // A zero gap gives a negative cap, so the target crosses the bound.
    send_one(element(5, 5, 5, 1'b1, 1'b1, 1'b0));
    send_one(element(WMAX, 5, 5, 1'b1, 1'b1, 1'b0));
    // The widest gap, and reversed bounds that are not both active.
    send_one(element(WMIN, WMIN, WMAX, 1'b1, 1'b1, 1'b0));
    send_one(element(WMIN, 100, -100, 1'b1, 1'b0, 1'b0));
    send_one(element(WMAX, 100, -100, 1'b0, 1'b1, 1'b1));
    // A clean one-element vector reports success.
    send_one(element(WMIN, -WONE, WONE, 1'b1, 1'b1, 1'b1));
    // Inverted bounds fail the vector; later elements pass unchanged until the last.
    send_one(element(123, 10, -10, 1'b1, 1'b1, 1'b0));
    send_one(element(WMIN, 0, 0, 1'b1, 1'b0, 1'b0));
    send_one(element(WMAX, -WONE, WONE, 1'b1, 1'b1, 1'b0));
    send_one(element(WMAX, -WONE, WONE, 1'b0, 1'b1, 1'b1));
    // The flag must be clear again for the next vector.
    send_one(element(WMIN, -WONE, WONE, 1'b1, 1'b1, 1'b1));
    // Inverted bounds on the last element itself, with all bits set.
    send_one(element(-1, -1, WMIN, 1'b1, 1'b1, 1'b1));
    send_one(element(-1, -1, -1, 1'b1, 1'b1, 1'b1));

    // Random phases, each with its own register setting and idling pattern.
    // Registers change only once the pipeline has run dry.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      pf = (PHASE_PF[p] < 0) ? KW'($urandom_range(131071)) : KW'(PHASE_PF[p]);
      gf = (PHASE_GF[p] < 0) ? KW'($urandom_range(131071)) : KW'(PHASE_GF[p]);
      // Writes to the unused indexes must leave both registers alone.
      write_reg(CFG_SPARE_A, KW'($urandom));
      write_reg(CFG_SPARE_B, {KW{1'b1}});
      write_reg(REG_PUSH_FACTOR, pf);
      write_reg(REG_GAP_FRACTION, gf);
      cfg_wr_en  <= 1'b0;
      send_idle  = PHASE_SIDLE[p];
      recv_stall = PHASE_RSTALL[p];
      send_vectors(PHASE_ITEMS, p == 3);
    end

    // Let the last results out, then give the pipeline time to show anything extra.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
